>>> rtl/cta_pkg.sv
`timescale 1ns / 1ps

package cta_pkg;

    // Operator and mode letters (ASCII)
    localparam logic [7:0] CH_M_UC = 8'h4D;  // 'M'
    localparam logic [7:0] CH_M_LC = 8'h6D;  // 'm'
    localparam logic [7:0] CH_D_UC = 8'h44;  // 'D'
    localparam logic [7:0] CH_D_LC = 8'h64;  // 'd'
    localparam logic [7:0] CH_I_UC = 8'h49;  // 'I'
    localparam logic [7:0] CH_I_LC = 8'h69;  // 'i'
    localparam logic [7:0] CH_F_UC = 8'h46;  // 'F'
    localparam logic [7:0] CH_F_LC = 8'h66;  // 'f'
    localparam logic [7:0] CH_R_UC = 8'h52;  // 'R'
    localparam logic [7:0] CH_R_LC = 8'h72;  // 'r'
    localparam logic [7:0] CH_X_UC = 8'h58;  // 'X'
    localparam logic [7:0] CH_L_UC = 8'h4C;  // 'L'
    localparam logic [7:0] CH_N_UC = 8'h4E;  // 'N'
    localparam logic [7:0] CH_T_UC = 8'h54;  // 'T'
    localparam logic [7:0] CH_P_UC = 8'h50;  // 'P'

    localparam int CoordW  = 32;
    localparam int LengthW = 24;
    localparam int CfgIdxW = 3;

    localparam logic [7:0] MODE_RESET = CH_N_UC;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SEARCH_MODE   = 3'd0,
        REG_REF_FORWARD   = 3'd1,
        REG_MATCH_FORWARD = 3'd2,
        REG_REF_LOW       = 3'd3,
        REG_REF_HIGH      = 3'd4,
        REG_MATCH_LOW     = 3'd5,
        REG_MATCH_HIGH    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FRAMESHIFT = 2'd1,
        ST_UNKNOWN_OP = 2'd2,
        ST_SKIPPED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]         op_char;
        logic [LengthW-1:0] op_length;
        logic               string_start;
    } in_item_t;

    typedef struct packed {
        logic                     range_valid;
        logic signed [CoordW-1:0] ref_begin;
        logic signed [CoordW-1:0] ref_end;
        logic signed [CoordW-1:0] match_begin;
        logic signed [CoordW-1:0] match_end;
        logic [1:0]               status;
        logic                     mode_unknown;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         search_mode;
        logic               ref_forward;
        logic               match_forward;
        logic [CoordW-1:0]  ref_low;
        logic [CoordW-1:0]  ref_high;
        logic [CoordW-1:0]  match_low;
        logic [CoordW-1:0]  match_high;
    } cfg_t;

endpackage

>>> rtl/cigar_to_aligned_ranges.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_item_t   (op_char, op_length, string_start)
// out       output     out_valid/out_stall out_item_t  (range, status, mode_unknown)
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One operation per cycle sustained while the output is not stalled.
// Input register feeds the cursor update logic, which loads the result register.
// Cursors and the error latch update when an item moves into the result register.
// Reset clears cursors and error latch, and loads register defaults (mode 'N', forward).
// A stalled output holds the pipeline; in_stall is raised only while the input stage is full.

module cigar_to_aligned_ranges
    import cta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CoordW-1:0]  cfg_data
);

    cfg_t      cfg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t step_result;
    logic      out_free;
    logic      s1_adv;
    logic      in_xfer;

    assign cfg_ready = 1'b1;

    cta_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= in_data;
        end
    end

    cta_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (s1_item_reg),
        .advance (s1_adv),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    a_range_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.range_valid) |-> (out_data.status == ST_OK))
        else $error("range reported with error status");

    a_no_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.range_valid) |->
        (out_data.ref_begin == '0 && out_data.ref_end == '0 &&
         out_data.match_begin == '0 && out_data.match_end == '0))
        else $error("nonzero coordinates without a range");

    a_start_not_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_item_reg.string_start) |=> (out_data.status != ST_SKIPPED))
        else $error("string start was skipped");

endmodule

>>> rtl/cta_cfg_regs.sv
`timescale 1ns / 1ps

module cta_cfg_regs
    import cta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [CfgIdxW-1:0] wr_index,
    input  logic [CoordW-1:0]  wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SEARCH_MODE:   cfg_next.search_mode   = wr_data[7:0];
                REG_REF_FORWARD:   cfg_next.ref_forward   = wr_data[0];
                REG_MATCH_FORWARD: cfg_next.match_forward = wr_data[0];
                REG_REF_LOW:       cfg_next.ref_low       = wr_data;
                REG_REF_HIGH:      cfg_next.ref_high      = wr_data;
                REG_MATCH_LOW:     cfg_next.match_low     = wr_data;
                REG_MATCH_HIGH:    cfg_next.match_high    = wr_data;
                default:           cfg_next = cfg_reg;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.search_mode   <= MODE_RESET;
            cfg_reg.ref_forward   <= 1'b1;
            cfg_reg.match_forward <= 1'b1;
            cfg_reg.ref_low       <= '0;
            cfg_reg.ref_high      <= '0;
            cfg_reg.match_low     <= '0;
            cfg_reg.match_high    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/cta_step.sv
`timescale 1ns / 1ps

module cta_step
    import cta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  item,
    input  logic      advance,
    output out_item_t result
);

    localparam logic [CoordW-1:0] CoordOne = 1;

    logic [CoordW-1:0] ref_cur_reg;
    logic [CoordW-1:0] ref_cur_next;
    logic [CoordW-1:0] match_cur_reg;
    logic [CoordW-1:0] match_cur_next;
    logic              err_reg;
    logic              err_next;

    logic              three_frames;
    logic              mode_unknown;
    logic [CoordW-1:0] len_ext;
    logic [CoordW-1:0] nref;
    logic [CoordW-1:0] ref_base;
    logic [CoordW-1:0] match_base;
    logic [CoordW-1:0] ref_first;
    logic [CoordW-1:0] ref_far;
    logic [CoordW-1:0] match_first;
    logic [CoordW-1:0] match_far;
    logic              skip;

    always_comb
    begin
        three_frames = 1'b0;
        mode_unknown = 1'b0;
        case (cfg.search_mode) inside
            CH_X_UC, CH_L_UC:          three_frames = 1'b1;
            CH_N_UC, CH_T_UC, CH_P_UC: three_frames = 1'b0;
            default:                   mode_unknown = 1'b1;
        endcase
    end

    assign len_ext = {{(CoordW-LengthW){1'b0}}, item.op_length};
    assign nref    = three_frames ? ((len_ext << 1) + len_ext) : len_ext;

    // cursors reload to one step outside the range on a string start
    always_comb
    begin
        if (item.string_start)
        begin
            ref_base   = cfg.ref_forward ? cfg.ref_low - CoordOne : cfg.ref_high + CoordOne;
            match_base = cfg.match_forward ? cfg.match_low - CoordOne
                                           : cfg.match_high + CoordOne;
        end
        else
        begin
            ref_base   = ref_cur_reg;
            match_base = match_cur_reg;
        end
    end

    // begin + (n - 1) collapses to base + n
    assign ref_first   = cfg.ref_forward   ? ref_base + CoordOne   : ref_base - CoordOne;
    assign ref_far     = cfg.ref_forward   ? ref_base + nref       : ref_base - nref;
    assign match_first = cfg.match_forward ? match_base + CoordOne : match_base - CoordOne;
    assign match_far   = cfg.match_forward ? match_base + len_ext : match_base - len_ext;

    assign skip = err_reg && !item.string_start;

    always_comb
    begin
        result              = '0;
        result.mode_unknown = mode_unknown;
        result.status       = ST_OK;
        ref_cur_next        = ref_base;
        match_cur_next      = match_base;
        err_next            = 1'b0;
        if (skip)
        begin
            result.status  = ST_SKIPPED;
            err_next       = 1'b1;
        end
        else
        begin
            case (item.op_char) inside
                CH_M_UC, CH_M_LC:
                begin
                    result.range_valid = 1'b1;
                    result.ref_begin   = ref_first;
                    result.ref_end     = ref_far;
                    result.match_begin = match_first;
                    result.match_end   = match_far;
                    ref_cur_next       = ref_far;
                    match_cur_next     = match_far;
                end
                CH_D_UC, CH_D_LC:
                begin
                    ref_cur_next = ref_far;
                end
                CH_I_UC, CH_I_LC:
                begin
                    match_cur_next = match_far;
                end
                CH_F_UC, CH_F_LC, CH_R_UC, CH_R_LC:
                begin
                    result.status = ST_FRAMESHIFT;
                    err_next      = 1'b1;
                end
                default:
                begin
                    result.status = ST_UNKNOWN_OP;
                    err_next      = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_cur_reg   <= '0;
            match_cur_reg <= '0;
            err_reg       <= 1'b0;
        end
        else if (advance)
        begin
            ref_cur_reg   <= ref_cur_next;
            match_cur_reg <= match_cur_next;
            err_reg       <= err_next;
        end
    end

endmodule
